>>> rtl/core/tssc_pkg.sv
// Shared constants for the tri-scanner sector classifier.
// Register indexes, fixed register widths and reset values. No dependencies.
package tssc_pkg;

  localparam int CFG_INDEX_BITS  = 3;
  localparam int SECTOR_LEN_BITS = 11;

  localparam logic [CFG_INDEX_BITS-1:0] REG_SECTOR_MODE = 3'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_SECTOR_LEN  = 3'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_LOWER_LIMIT = 3'd2;
  localparam logic [CFG_INDEX_BITS-1:0] REG_UPPER_LIMIT = 3'd3;
  localparam logic [CFG_INDEX_BITS-1:0] REG_MAX_DELTA   = 3'd4;

  localparam int SECTOR_MODE_RST = 1;
  localparam int SECTOR_LEN_RST  = 20;
  localparam int LOWER_LIMIT_RST = 100;
  localparam int UPPER_LIMIT_RST = 30000;
  localparam int MAX_DELTA_RST   = 3000;

  // danger range ceiling, mm
  localparam int DANGER_CAP = 100000;

endpackage

>>> rtl/core/tssc_classify.sv
// Combinational classification of one (low, mid, high) range triple.
// Gating, clear/danger/building/roof selection, mean of three. Uses tssc_pkg.
module tssc_classify #(
  parameter int RANGE_BITS = 16
) (
  input  logic [RANGE_BITS-1:0] low,
  input  logic [RANGE_BITS-1:0] mid,
  input  logic [RANGE_BITS-1:0] high,
  input  logic [RANGE_BITS-1:0] lower_limit,
  input  logic [RANGE_BITS-1:0] upper_limit,
  input  logic [RANGE_BITS-1:0] max_delta,
  output logic [RANGE_BITS-1:0] clear_range,
  output logic [RANGE_BITS-1:0] danger_range,
  output logic [RANGE_BITS-1:0] building_range,
  output logic [RANGE_BITS-1:0] roof_range
);
  import tssc_pkg::*;

  localparam int SUM_BITS  = RANGE_BITS + 2;
  localparam int SHIFT     = SUM_BITS + 2;
  localparam int PROD_BITS = SUM_BITS + SHIFT;
  // ceil(2^SHIFT / 3): exact floor division by 3 for SUM_BITS-bit sums
  localparam logic [SHIFT-1:0] RECIP3 = SHIFT'(((64'd1 << SHIFT) + 64'd2) / 64'd3);

  logic                  vl, vm, vh;
  logic [RANGE_BITS-1:0] mn, mx, lm_diff, vmin;
  logic [SUM_BITS-1:0]   sum;
  logic [PROD_BITS-1:0]  prod;
  logic [RANGE_BITS-1:0] mean;

  assign vl = (low  != '1) && (low  > lower_limit) && (low  < upper_limit);
  assign vm = (mid  != '1) && (mid  > lower_limit) && (mid  < upper_limit);
  assign vh = (high != '1) && (high > lower_limit) && (high < upper_limit);

  assign sum  = SUM_BITS'(low) + SUM_BITS'(mid) + SUM_BITS'(high);
  assign prod = PROD_BITS'(sum) * PROD_BITS'(RECIP3);
  assign mean = prod[SHIFT +: RANGE_BITS];

  always_comb begin
    mn = (low < mid) ? low : mid;
    mn = (high < mn) ? high : mn;
    mx = (low > mid) ? low : mid;
    mx = (high > mx) ? high : mx;
    lm_diff = (mid > low) ? (mid - low) : (low - mid);
    vmin = '1;
    if (vl && low < vmin) vmin = low;
    if (vm && mid < vmin) vmin = mid;
    if (vh && high < vmin) vmin = high;
    if (32'(vmin) > DANGER_CAP) vmin = RANGE_BITS'(DANGER_CAP);
  end

  always_comb begin
    clear_range    = '0;
    danger_range   = '0;
    building_range = '0;
    roof_range     = '0;
    if (!vl && !vm && !vh) begin
      clear_range = upper_limit;
    end else if (vl && vm && vh) begin
      danger_range = mn;
      if ((mx - mn) < max_delta) building_range = mean;
    end else if (vl && !vm && !vh) begin
      roof_range = low;
    end else if (vl && vm && !vh && (lm_diff < max_delta)) begin
      roof_range = low;
    end else begin
      danger_range = vmin;
    end
  end

endmodule

>>> rtl/core/tri_scan_sector_classifier_core.sv
// An accepted closing beam is registered in stage A, classified, then registered in the result register.
// Throughput: one beam per cycle while in_stall is low; per-scanner minima and classification are combinational.
// Non-closing beams in sector mode produce no result; the output register holds one
// result while the next beam is taken. Reset (rst, synchronous) restores register
// defaults, clears the sector minima to all ones, the beam count to zero, and empties the pipe.
module tri_scan_sector_classifier_core #(
  parameter int MAX_SECTOR_LEN = 1024,
  parameter int RANGE_BITS     = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [tssc_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [((RANGE_BITS > tssc_pkg::SECTOR_LEN_BITS) ? RANGE_BITS :
                 tssc_pkg::SECTOR_LEN_BITS)-1:0] cfg_data,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [RANGE_BITS-1:0]               low_range,
  input  logic [RANGE_BITS-1:0]               mid_range,
  input  logic [RANGE_BITS-1:0]               high_range,
  input  logic                                end_of_scan,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [RANGE_BITS-1:0]               clear_range,
  output logic [RANGE_BITS-1:0]               danger_range,
  output logic [RANGE_BITS-1:0]               building_range,
  output logic [RANGE_BITS-1:0]               roof_range,
  output logic                                last_of_scan
);
  import tssc_pkg::*;

  localparam int CNT_BITS = (MAX_SECTOR_LEN > 1) ? $clog2(MAX_SECTOR_LEN) : 1;
  localparam int LEN_BITS = ($clog2(MAX_SECTOR_LEN + 1) > SECTOR_LEN_BITS) ?
                            $clog2(MAX_SECTOR_LEN + 1) : SECTOR_LEN_BITS;

  logic                       sector_mode;
  logic [SECTOR_LEN_BITS-1:0] sector_len;
  logic [RANGE_BITS-1:0]      lower_limit, upper_limit, max_delta;

  logic [RANGE_BITS-1:0]      low_min, mid_min, high_min;
  logic [CNT_BITS-1:0]        beam_in_sector;

  logic                       a_valid, a_eos;
  logic [RANGE_BITS-1:0]      a_low, a_mid, a_high;

  logic                       in_accept, out_free, a_free, sector_done;
  logic [RANGE_BITS-1:0]      low_cur, mid_cur, high_cur;
  logic [LEN_BITS-1:0]        len_raw, len_eff;
  logic [RANGE_BITS-1:0]      c_clear, c_danger, c_building, c_roof;

  // config
  always_ff @(posedge clk) begin
    if (rst) begin
      sector_mode <= 1'(SECTOR_MODE_RST);
      sector_len  <= SECTOR_LEN_BITS'(SECTOR_LEN_RST);
      lower_limit <= RANGE_BITS'(LOWER_LIMIT_RST);
      upper_limit <= RANGE_BITS'(UPPER_LIMIT_RST);
      max_delta   <= RANGE_BITS'(MAX_DELTA_RST);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SECTOR_MODE: sector_mode <= cfg_data[0];
        REG_SECTOR_LEN:  sector_len  <= cfg_data[SECTOR_LEN_BITS-1:0];
        REG_LOWER_LIMIT: lower_limit <= cfg_data[RANGE_BITS-1:0];
        REG_UPPER_LIMIT: upper_limit <= cfg_data[RANGE_BITS-1:0];
        REG_MAX_DELTA:   max_delta   <= cfg_data[RANGE_BITS-1:0];
        default: ;
      endcase
    end
  end

  // handshake
  assign out_free  = !out_valid || !out_stall;
  assign a_free    = !a_valid || out_free;
  assign in_stall  = !a_free;
  assign in_accept = in_valid && !in_stall;

  // running minima
  always_comb begin
    if (sector_mode) begin
      low_cur  = (low_range  < low_min)  ? low_range  : low_min;
      mid_cur  = (mid_range  < mid_min)  ? mid_range  : mid_min;
      high_cur = (high_range < high_min) ? high_range : high_min;
    end else begin
      low_cur  = low_range;
      mid_cur  = mid_range;
      high_cur = high_range;
    end
    len_raw = LEN_BITS'(sector_len);
    if (len_raw == '0) begin
      len_eff = LEN_BITS'(1);
    end else if (len_raw > LEN_BITS'(MAX_SECTOR_LEN)) begin
      len_eff = LEN_BITS'(MAX_SECTOR_LEN);
    end else begin
      len_eff = len_raw;
    end
    sector_done = !sector_mode || end_of_scan ||
                  ((LEN_BITS'(beam_in_sector) + LEN_BITS'(1)) >= len_eff);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      low_min        <= '1;
      mid_min        <= '1;
      high_min       <= '1;
      beam_in_sector <= '0;
    end else if (in_accept) begin
      if (sector_done) begin
        low_min        <= '1;
        mid_min        <= '1;
        high_min       <= '1;
        beam_in_sector <= '0;
      end else begin
        low_min        <= low_cur;
        mid_min        <= mid_cur;
        high_min       <= high_cur;
        beam_in_sector <= beam_in_sector + CNT_BITS'(1);
      end
    end
  end

  // stage A: closed sector or passed beam
  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (a_free) begin
      a_valid <= in_accept && sector_done;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      a_low  <= low_cur;
      a_mid  <= mid_cur;
      a_high <= high_cur;
      a_eos  <= end_of_scan;
    end
  end

  tssc_classify #(
    .RANGE_BITS(RANGE_BITS)
  ) u_classify (
    .low           (a_low),
    .mid           (a_mid),
    .high          (a_high),
    .lower_limit   (lower_limit),
    .upper_limit   (upper_limit),
    .max_delta     (max_delta),
    .clear_range   (c_clear),
    .danger_range  (c_danger),
    .building_range(c_building),
    .roof_range    (c_roof)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && a_valid) begin
      clear_range    <= c_clear;
      danger_range   <= c_danger;
      building_range <= c_building;
      roof_range     <= c_roof;
      last_of_scan   <= a_eos;
    end
  end

`ifndef SYNTHESIS
  a_clear_alone: assert property (@(posedge clk) disable iff (rst)
    out_valid && clear_range != '0 |->
      danger_range == '0 && building_range == '0 && roof_range == '0)
    else $error("clear result carries other ranges");

  a_building_danger: assert property (@(posedge clk) disable iff (rst)
    out_valid && building_range != '0 |->
      danger_range != '0 && danger_range <= building_range && roof_range == '0)
    else $error("building range without matching danger range");

  a_pass_clears: assert property (@(posedge clk) disable iff (rst)
    in_accept && !sector_mode |=>
      beam_in_sector == '0 && low_min == '1 && mid_min == '1 && high_min == '1)
    else $error("pass mode left sector state");

  a_eos_emits: assert property (@(posedge clk) disable iff (rst)
    in_accept && end_of_scan |=> a_valid && a_eos)
    else $error("end of scan beam did not close sector");
`endif

endmodule

>>> sim/tb_tri_scan_sector_classifier_core.sv
`timescale 1ns / 1ps
// Self-checking testbench for tri_scan_sector_classifier_core: directed and random beams with
// random idling, checked against an in-bench predictor of per-beam and per-sector results.
// Depends on tssc_pkg and the core RTL.
module tb_tri_scan_sector_classifier_core;
  import tssc_pkg::*;

  localparam int RANGE_BITS     = 16;
  localparam int MAX_SECTOR_LEN = 1024;
  localparam logic [15:0] INF_RANGE = 16'hFFFF;

  typedef struct packed {
    logic [15:0] low;
    logic [15:0] mid;
    logic [15:0] high;
    logic        eos;
  } beam_t;

  typedef struct packed {
    logic [15:0] clear_r;
    logic [15:0] danger_r;
    logic [15:0] building_r;
    logic [15:0] roof_r;
    logic        last;
  } class_t;

  typedef struct packed {
    logic        sector_mode;
    logic [15:0] sector_len;
    logic [15:0] lower_limit;
    logic [15:0] upper_limit;
    logic [15:0] max_delta;
  } sector_cfg_t;

  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      cfg_we = 1'b0;
  logic [CFG_INDEX_BITS-1:0] cfg_index = REG_SECTOR_MODE;
  logic [15:0]               cfg_data = 16'd0;
  logic                      in_valid = 1'b0;
  logic                      in_stall;
  logic [15:0]               low_range = 16'd0;
  logic [15:0]               mid_range = 16'd0;
  logic [15:0]               high_range = 16'd0;
  logic                      end_of_scan = 1'b0;
  logic                      out_valid;
  logic                      out_stall = 1'b0;
  logic [15:0]               clear_range;
  logic [15:0]               danger_range;
  logic [15:0]               building_range;
  logic [15:0]               roof_range;
  logic                      last_of_scan;

  sector_cfg_t cfg_m;
  logic [15:0] low_min_m, mid_min_m, high_min_m;
  int          beams_held;
  class_t      classified_q[$];
  int          err_count = 0;
  int          send_idle_pct = 0;
  int          stall_pct = 0;

  tri_scan_sector_classifier_core #(
    .MAX_SECTOR_LEN(MAX_SECTOR_LEN),
    .RANGE_BITS    (RANGE_BITS)
  ) u_top (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .low_range     (low_range),
    .mid_range     (mid_range),
    .high_range    (high_range),
    .end_of_scan   (end_of_scan),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .clear_range   (clear_range),
    .danger_range  (danger_range),
    .building_range(building_range),
    .roof_range    (roof_range),
    .last_of_scan  (last_of_scan)
  );

  always #4 clk = ~clk;

  // ---------------- predictor ----------------

  function automatic void clear_minima();
    low_min_m  = INF_RANGE;
    mid_min_m  = INF_RANGE;
    high_min_m = INF_RANGE;
    beams_held = 0;
  endfunction

  function automatic void reset_model();
    cfg_m.sector_mode = (SECTOR_MODE_RST != 0);
    cfg_m.sector_len  = 16'(SECTOR_LEN_RST);
    cfg_m.lower_limit = 16'(LOWER_LIMIT_RST);
    cfg_m.upper_limit = 16'(UPPER_LIMIT_RST);
    cfg_m.max_delta   = 16'(MAX_DELTA_RST);
    clear_minima();
  endfunction

  function automatic bit in_window(logic [15:0] v);
    return v != INF_RANGE && v > cfg_m.lower_limit && v < cfg_m.upper_limit;
  endfunction

  function automatic class_t classify_ranges(logic [15:0] lo, logic [15:0] mi, logic [15:0] hi);
    class_t      r;
    bit          vl, vm, vh;
    logic [15:0] mn, mx, gap_mm;
    logic [17:0] sum, quot;
    int          nearest;
    r  = '0;
    vl = in_window(lo);
    vm = in_window(mi);
    vh = in_window(hi);
    if (!vl && !vm && !vh) begin
      r.clear_r = cfg_m.upper_limit;
    end else if (vl && vm && vh) begin
      mn = lo;
      if (mi < mn) mn = mi;
      if (hi < mn) mn = hi;
      mx = lo;
      if (mi > mx) mx = mi;
      if (hi > mx) mx = hi;
      r.danger_r = mn;
      if (mx - mn < cfg_m.max_delta) begin
        sum  = {2'b00, lo} + {2'b00, mi} + {2'b00, hi};
        quot = sum / 18'd3;
        r.building_r = quot[15:0];
      end
    end else if (vl && !vm && !vh) begin
      r.roof_r = lo;
    end else begin
      gap_mm = (mi > lo) ? mi - lo : lo - mi;
      if (vl && vm && !vh && gap_mm < cfg_m.max_delta) begin
        r.roof_r = lo;
      end else begin
        nearest = DANGER_CAP;
        if (vl && lo < nearest) nearest = lo;
        if (vm && mi < nearest) nearest = mi;
        if (vh && hi < nearest) nearest = hi;
        r.danger_r = nearest[15:0];
      end
    end
    return r;
  endfunction

  // Returns 1 when the beam produces a result.
  function automatic bit classify_beam(beam_t b, output class_t r);
    int span;
    r = '0;
    if (!cfg_m.sector_mode) begin
      clear_minima();
      r = classify_ranges(b.low, b.mid, b.high);
      r.last = b.eos;
      return 1'b1;
    end
    span = int'(cfg_m.sector_len[SECTOR_LEN_BITS-1:0]);
    if (span == 0) span = 1;
    if (span > MAX_SECTOR_LEN) span = MAX_SECTOR_LEN;
    if (b.low < low_min_m) low_min_m = b.low;
    if (b.mid < mid_min_m) mid_min_m = b.mid;
    if (b.high < high_min_m) high_min_m = b.high;
    if (beams_held + 1 >= span || b.eos) begin
      r = classify_ranges(low_min_m, mid_min_m, high_min_m);
      r.last = b.eos;
      clear_minima();
      return 1'b1;
    end
    beams_held++;
    return 1'b0;
  endfunction

  // ---------------- checking ----------------

  function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
    if (got !== want) begin
      $error("%s expected %0d got %0d", name, want, got);
      err_count++;
    end
  endfunction

  always @(posedge clk) begin : result_check
    class_t want;
    if (!rst && out_valid && !out_stall) begin
      if (classified_q.size() == 0) begin
        $error("unexpected result: clear_range %0d danger_range %0d", clear_range,
               danger_range);
        err_count++;
      end else begin
        want = classified_q.pop_front();
        check_field("clear_range", want.clear_r, clear_range);
        check_field("danger_range", want.danger_r, danger_range);
        check_field("building_range", want.building_r, building_range);
        check_field("roof_range", want.roof_r, roof_range);
        check_field("last_of_scan", {15'd0, want.last}, {15'd0, last_of_scan});
      end
    end
  end

  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  // ---------------- drivers ----------------

  function automatic logic [15:0] rand16(int lo, int hi);
    logic [31:0] v;
    v = $urandom_range(hi, lo);
    return v[15:0];
  endfunction

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (classified_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic program_regs(sector_cfg_t c);
    wait_drained();
    cfg_we    <= 1'b1;
    cfg_index <= REG_SECTOR_MODE;
    cfg_data  <= {15'd0, c.sector_mode};
    @(posedge clk);
    cfg_index <= REG_SECTOR_LEN;
    cfg_data  <= c.sector_len;
    @(posedge clk);
    cfg_index <= REG_LOWER_LIMIT;
    cfg_data  <= c.lower_limit;
    @(posedge clk);
    cfg_index <= REG_UPPER_LIMIT;
    cfg_data  <= c.upper_limit;
    @(posedge clk);
    cfg_index <= REG_MAX_DELTA;
    cfg_data  <= c.max_delta;
    @(posedge clk);
    cfg_we <= 1'b0;
    cfg_m = c;
  endtask

  task automatic send_beam(beam_t b);
    class_t r;
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid    <= 1'b0;
      low_range   <= rand16(0, 65535);
      mid_range   <= rand16(0, 65535);
      high_range  <= rand16(0, 65535);
      end_of_scan <= ($urandom_range(99) < 50);
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid    <= 1'b1;
    low_range   <= b.low;
    mid_range   <= b.mid;
    high_range  <= b.high;
    end_of_scan <= b.eos;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (classify_beam(b, r)) classified_q.push_back(r);
  endtask

  task automatic set_idling(int mode);
    case (mode)
      0: begin send_idle_pct = 0;  stall_pct = 0;  end
      1: begin send_idle_pct = 71; stall_pct = 0;  end
      2: begin send_idle_pct = 0;  stall_pct = 71; end
      default: begin send_idle_pct = 16; stall_pct = 16; end
    endcase
  endtask

  function automatic beam_t make_beam(logic [15:0] lo, logic [15:0] mi, logic [15:0] hi,
                                      logic eos);
    beam_t b;
    b.low  = lo;
    b.mid  = mi;
    b.high = hi;
    b.eos  = eos;
    return b;
  endfunction

  function automatic sector_cfg_t cfg_of(logic us, int len, int rmin, int rmax, int delta);
    sector_cfg_t c;
    c.sector_mode = us;
    c.sector_len  = len[15:0];
    c.lower_limit = rmin[15:0];
    c.upper_limit = rmax[15:0];
    c.max_delta   = delta[15:0];
    return c;
  endfunction

  // ---------------- random stimulus ----------------

  function automatic logic [15:0] window_value();
    int lo_i, hi_i;
    lo_i = cfg_m.lower_limit;
    hi_i = cfg_m.upper_limit;
    if (hi_i > lo_i + 1) return rand16(lo_i + 1, hi_i - 1);
    return rand16(0, 65535);
  endfunction

  function automatic logic [15:0] pick_range();
    int v;
    case ($urandom_range(11))
      0:       v = 0;
      1:       v = 65535;
      2:       v = cfg_m.lower_limit;
      3:       v = int'(cfg_m.upper_limit);
      4:       v = int'(cfg_m.lower_limit) + 1;
      5:       v = int'(cfg_m.upper_limit) - 1;
      6, 7:    v = rand16(0, 65535);
      default: v = window_value();
    endcase
    return v[15:0];
  endfunction

  function automatic logic [15:0] near_value(logic [15:0] base);
    int span, v;
    span = (cfg_m.max_delta > 4000) ? 4000 : int'(cfg_m.max_delta);
    span = span + 2;
    v = int'(base) + int'($urandom_range(2 * span)) - span;
    if (v < 0) v = 0;
    if (v > 65535) v = 65535;
    return v[15:0];
  endfunction

  // Mostly one surface seen by all scanners, with some scanners knocked out.
  function automatic beam_t random_beam(int noise_pct, int eos_pct);
    beam_t       b;
    logic [15:0] base;
    if ($urandom_range(99) >= noise_pct) begin
      base   = window_value();
      b.low  = base;
      b.mid  = near_value(base);
      b.high = near_value(base);
      case ($urandom_range(6))
        0: b.high = INF_RANGE;
        1: b.high = 16'd0;
        2: begin b.mid = INF_RANGE; b.high = INF_RANGE; end
        3: b.low = INF_RANGE;
        default: ;
      endcase
    end else begin
      b.low  = pick_range();
      b.mid  = pick_range();
      b.high = pick_range();
    end
    b.eos = ($urandom_range(99) < eos_pct);
    return b;
  endfunction

  function automatic sector_cfg_t random_cfg(logic sectors);
    sector_cfg_t c;
    c.sector_mode = sectors;
    case ($urandom_range(7))
      0:       c.sector_len = 16'd0;
      1:       c.sector_len = 16'd1;
      7:       c.sector_len = rand16(13, 48);
      default: c.sector_len = rand16(2, 12);
    endcase
    case ($urandom_range(5))
      0:       c.lower_limit = 16'd0;
      1:       c.lower_limit = rand16(0, 65535);
      default: c.lower_limit = rand16(0, 2000);
    endcase
    case ($urandom_range(5))
      0:       c.upper_limit = 16'hFFFF;
      1:       c.upper_limit = rand16(0, 65535);
      default: c.upper_limit = rand16(c.lower_limit, 65535);
    endcase
    case ($urandom_range(6))
      0:       c.max_delta = 16'd0;
      1:       c.max_delta = 16'hFFFF;
      2:       c.max_delta = rand16(0, 65535);
      default: c.max_delta = rand16(0, 6000);
    endcase
    return c;
  endfunction

  task automatic run_phase(int idle_mode, int beams);
    int noise, eos_pct;
    set_idling(idle_mode);
    noise   = cfg_m.sector_mode ? 10 : 45;
    eos_pct = cfg_m.sector_mode ? 8 : 50;
    repeat (beams) begin
      send_beam(random_beam(noise, eos_pct));
      if ($urandom_range(99) == 0) wait_drained();
    end
  endtask

  // ---------------- tests ----------------

  task automatic test_reset_config();
    run_phase(3, 60);
  endtask

  task automatic test_pass_classes();
    set_idling(0);
    program_regs(cfg_of(1'b0, 20, 100, 30000, 3000));
    send_beam(make_beam(16'd0, 16'd0, 16'd0, 1'b0));
    send_beam(make_beam(16'd100, 16'd30000, INF_RANGE, 1'b0));
    send_beam(make_beam(16'd1000, 16'd1500, 16'd2000, 1'b1));
    send_beam(make_beam(16'd1000, 16'd4000, 16'd2000, 1'b0));
    send_beam(make_beam(16'd1000, 16'd3999, 16'd2000, 1'b0));
    send_beam(make_beam(16'd5000, 16'd0, INF_RANGE, 1'b1));
    send_beam(make_beam(16'd5000, 16'd7999, INF_RANGE, 1'b0));
    send_beam(make_beam(16'd5000, 16'd8000, 16'd0, 1'b0));
    send_beam(make_beam(16'd0, 16'd700, 16'd0, 1'b0));
    send_beam(make_beam(16'd0, 16'd0, 16'd29999, 1'b1));
    send_beam(make_beam(16'd101, INF_RANGE, 16'd200, 1'b0));
    send_beam(make_beam(16'd30001, 16'd150, 16'd29999, 1'b0));
    program_regs(cfg_of(1'b0, 20, 0, 65535, 65535));
    send_beam(make_beam(16'd1, 16'd65534, 16'd65534, 1'b1));
    program_regs(cfg_of(1'b0, 20, 65535, 0, 0));
    send_beam(make_beam(16'd1234, INF_RANGE, 16'd0, 1'b1));
    // zero spread limit: no surface and no roof even for equal ranges
    program_regs(cfg_of(1'b0, 20, 100, 30000, 0));
    send_beam(make_beam(16'd500, 16'd500, 16'd500, 1'b0));
    send_beam(make_beam(16'd500, 16'd500, INF_RANGE, 1'b0));
  endtask

  task automatic test_sector_edges();
    set_idling(0);
    program_regs(cfg_of(1'b1, 0, 100, 30000, 3000));
    send_beam(make_beam(16'd2000, 16'd2100, 16'd2200, 1'b0));
    send_beam(make_beam(16'd900, 16'd0, 16'd2200, 1'b0));
    program_regs(cfg_of(1'b1, 3, 100, 30000, 3000));
    send_beam(make_beam(16'd4000, 16'd4100, 16'd4200, 1'b0));
    send_beam(make_beam(16'd3900, 16'd5000, INF_RANGE, 1'b0));
    send_beam(make_beam(16'd6000, 16'd4050, 16'd4300, 1'b0));
    send_beam(make_beam(16'd8000, 16'd8000, 16'd8000, 1'b1));
    // a beam left in a sector must be dropped by pass mode
    send_beam(make_beam(16'd150, 16'd150, 16'd150, 1'b0));
    program_regs(cfg_of(1'b0, 3, 100, 30000, 3000));
    send_beam(make_beam(16'd7000, 16'd7000, 16'd0, 1'b0));
    program_regs(cfg_of(1'b1, 3, 100, 30000, 3000));
    send_beam(make_beam(16'd9000, 16'd9100, 16'd9200, 1'b0));
    send_beam(make_beam(16'd9300, 16'd9400, 16'd9500, 1'b0));
    send_beam(make_beam(16'd9600, 16'd9700, 16'd9800, 1'b0));
  endtask

  // sector length above the maximum saturates to a full 1024-beam sector
  task automatic test_long_sector();
    program_regs(cfg_of(1'b1, 2047, 100, 30000, 3000));
    set_idling(0);
    repeat (MAX_SECTOR_LEN) send_beam(random_beam(3, 0));
  endtask

  task automatic test_random_configs();
    for (int p = 0; p < 10; p++) begin
      program_regs(random_cfg(p % 3 != 2));
      run_phase(p % 4, $urandom_range(50, 70));
    end
  endtask

  initial begin
    reset_model();
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    test_reset_config();
    test_pass_classes();
    test_sector_edges();
    test_long_sector();
    test_random_configs();
    wait_drained();
    repeat (8) @(posedge clk);
    if (err_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("tb: failure");
    $finish;
  end

endmodule
